@@ sv/hkpt_pkg.sv @@
// Shared types, constants and the scancode table of the hex keypad tracker.
// Used by hkpt_list_ram and hex_keypad_press_order_tracker; depends on nothing.
package hkpt_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int KEY_SLOTS  = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	typedef struct packed {
		logic [8:0] key_scancode;
		logic [1:0] event_kind;
		logic [3:0] query_key;
	} hkpt_cmd_t;

	typedef struct packed {
		logic       query_key_down;
		logic [3:0] first_key;
		logic       first_key_valid;
		logic       scancode_mapped;
	} hkpt_rsp_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [3:0]       data;
	} hkpt_wr_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] key;
	} hkpt_key_t;

	// Fixed keyboard-to-keypad table; an unmapped scancode returns valid low.
	function automatic hkpt_key_t map_scancode(logic [8:0] sc);
		hkpt_key_t r;
		r.valid = 1'b1;
		unique case (sc)
			9'd30:   r.key = 4'd1;
			9'd31:   r.key = 4'd2;
			9'd32:   r.key = 4'd3;
			9'd33:   r.key = 4'd12;
			9'd20:   r.key = 4'd4;
			9'd26:   r.key = 4'd5;
			9'd8:    r.key = 4'd6;
			9'd21:   r.key = 4'd13;
			9'd4:    r.key = 4'd7;
			9'd22:   r.key = 4'd8;
			9'd7:    r.key = 4'd9;
			9'd9:    r.key = 4'd14;
			9'd29:   r.key = 4'd10;
			9'd27:   r.key = 4'd0;
			9'd6:    r.key = 4'd11;
			9'd25:   r.key = 4'd15;
			default: begin
				r.valid = 1'b0;
				r.key   = 4'd0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ sv/hkpt_list_ram.sv @@
// Press-order list storage: one write port, one registered read port.
// Depends on hkpt_pkg for the depth, index width and write bundle.
module hkpt_list_ram
	import hkpt_pkg::*;
(
	input  logic             clk,
	input  hkpt_wr_t         wr,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [3:0]       rd_data
);

	logic [3:0] mem [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ sv/hex_keypad_press_order_tracker.sv @@
// Top level of the hex keypad press-order tracker: sequencer, key mask and count.
// Depends on hkpt_pkg and instantiates hkpt_list_ram.
//
// A transaction is taken when start is high and busy is low. A press, a query or an
// ignored event passes through the decide, first and respond states to the done strobe; a
// release of a held key also passes through the pass state first, where the list memory
// is swept one entry per cycle through its single read port to find
// the key and close the gap. The result stands on the result port for exactly one cycle
// with done high, and must be taken then: the block does not wait. A new transaction may
// be started in the same cycle as the done strobe.
module hex_keypad_press_order_tracker
	import hkpt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  hkpt_cmd_t cmd,
	output logic      done,
	output hkpt_rsp_t result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PASS,
		ST_FIRST,
		ST_RESP
	} state_t;

	state_t           state_q;
	hkpt_cmd_t        cmd_q;
	hkpt_key_t        key_q;
	logic [15:0]      mask_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [IDX_W-1:0] jdx_q;
	logic             pend_q;
	logic             found_q;
	logic             done_q;
	hkpt_rsp_t        result_q;

	hkpt_wr_t         wr;
	logic [IDX_W-1:0] rd_addr;
	logic [3:0]       rd_data;
	logic             issue;

	assign issue = (state_q == ST_PASS) && (idx_q < count_q);

	always_comb begin
		wr      = '0;
		rd_addr = '0;
		unique case (state_q)
			ST_DECIDE: begin
				wr.en   = key_q.valid && (cmd_q.event_kind == EV_PRESS) &&
					!mask_q[key_q.key] && (count_q < CNT_W'(KEY_SLOTS));
				wr.addr = count_q[IDX_W-1:0];
				wr.data = key_q.key;
			end
			ST_PASS: begin
				rd_addr = idx_q[IDX_W-1:0];
				// Once the key is found, each later entry moves down one slot.
				wr.en   = pend_q && found_q;
				wr.addr = jdx_q - IDX_W'(1);
				wr.data = rd_data;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	hkpt_list_ram u_list (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			key_q    <= '0;
			mask_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			jdx_q    <= '0;
			pend_q   <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						key_q   <= map_scancode(cmd.key_scancode);
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					idx_q   <= '0;
					pend_q  <= 1'b0;
					found_q <= 1'b0;
					state_q <= ST_FIRST;
					if (wr.en) begin
						mask_q[key_q.key] <= 1'b1;
						count_q           <= count_q + CNT_W'(1);
					end else if (key_q.valid && (cmd_q.event_kind == EV_RELEASE) &&
						mask_q[key_q.key]) begin
						mask_q[key_q.key] <= 1'b0;
						state_q           <= ST_PASS;
					end
				end
				ST_PASS: begin
					pend_q <= issue;
					jdx_q  <= idx_q[IDX_W-1:0];
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (pend_q && !found_q && (rd_data == key_q.key)) begin
						found_q <= 1'b1;
					end
					if (!issue && !pend_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					result_q.query_key_down  <= mask_q[cmd_q.query_key];
					result_q.first_key       <= (count_q != '0) ? rd_data : 4'd0;
					result_q.first_key_valid <= (count_q != '0);
					result_q.scancode_mapped <= key_q.valid;
					done_q                   <= 1'b1;
					state_q                  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still running");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(KEY_SLOTS))
		else $error("pressed count beyond the slot limit");

	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_PASS) |-> ($countones(mask_q) == 32'(count_q)))
		else $error("key mask and pressed count disagree");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule

@@ test/hex_keypad_press_order_tracker_tb.sv @@
// Self-checking testbench for the hex keypad press-order tracker.
// Drives directed and random key transactions and checks each result against
// a typed value or the local predictor. Depends on hkpt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module hex_keypad_press_order_tracker_tb;
	import hkpt_pkg::*;

	localparam logic [1:0] EV_SPARE     = 2'd3;
	localparam int         DIRECTED_N   = 25;
	localparam int         RANDOM_N     = 1100;
	localparam int         DRAIN_CYCLES = 32;
	localparam int         CYCLE_LIMIT  = 500000;

	typedef struct packed {
		hkpt_cmd_t cmd;
		logic      typed;
		hkpt_rsp_t want;
	} key_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	hkpt_cmd_t cmd;
	logic      done;
	hkpt_rsp_t result;

	// Local copy of the pressed list, oldest key first.
	logic [3:0] held_keys [KEY_SLOTS];
	int         held_count;

	hkpt_rsp_t  expected_key_status [$];
	key_row_t   directed_rows [DIRECTED_N];
	int         mismatch_count;
	int         cycle_count;

	hex_keypad_press_order_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	function automatic logic [8:0] scancode_of_key(input logic [3:0] key);
		case (key)
			4'd0:    return 9'd27;
			4'd1:    return 9'd30;
			4'd2:    return 9'd31;
			4'd3:    return 9'd32;
			4'd4:    return 9'd20;
			4'd5:    return 9'd26;
			4'd6:    return 9'd8;
			4'd7:    return 9'd4;
			4'd8:    return 9'd22;
			4'd9:    return 9'd7;
			4'd10:   return 9'd29;
			4'd11:   return 9'd6;
			4'd12:   return 9'd33;
			4'd13:   return 9'd21;
			4'd14:   return 9'd9;
			default: return 9'd25;
		endcase
	endfunction

	function automatic int held_position(input logic [3:0] key);
		int pos;
		pos = held_count;
		for (int i = 0; i < held_count; i++)
			if (pos == held_count && held_keys[i] == key)
				pos = i;
		return pos;
	endfunction

	// Applies one key transaction to the local list and returns the status it yields.
	function automatic hkpt_rsp_t track_key_event(input hkpt_cmd_t c);
		hkpt_rsp_t r;
		int        key;
		int        pos;
		key = KEY_SLOTS;
		for (int k = 0; k < 16; k++)
			if (scancode_of_key(k[3:0]) == c.key_scancode)
				key = k;
		if (key < 16) begin
			pos = held_position(key[3:0]);
			if (c.event_kind == EV_PRESS) begin
				if (pos == held_count && held_count < KEY_SLOTS) begin
					held_keys[held_count] = key[3:0];
					held_count++;
				end
			end else if (c.event_kind == EV_RELEASE) begin
				if (pos < held_count) begin
					for (int i = pos; i + 1 < held_count; i++)
						held_keys[i] = held_keys[i + 1];
					held_count--;
				end
			end
		end
		r.query_key_down  = held_position(c.query_key) < held_count;
		r.first_key       = (held_count > 0) ? held_keys[0] : 4'd0;
		r.first_key_valid = held_count > 0;
		r.scancode_mapped = key < 16;
		return r;
	endfunction

	function automatic key_row_t key_row(input logic [8:0] sc, input logic [1:0] kind,
			input logic [3:0] query, input logic typed, input hkpt_rsp_t want);
		key_row_t row;
		row.cmd.key_scancode = sc;
		row.cmd.event_kind   = kind;
		row.cmd.query_key    = query;
		row.typed            = typed;
		row.want             = want;
		return row;
	endfunction

	// Mostly well-formed events on keypad keys; press-heavy and release-heavy phases
	// alternate so that the list both fills up and drains.
	function automatic hkpt_cmd_t random_key_event(input int press_pct);
		hkpt_cmd_t   c;
		int unsigned roll;
		logic [3:0]  key;
		c.query_key = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 15) begin
			c.key_scancode = 9'($urandom_range(0, 511));
			c.event_kind   = 2'($urandom_range(0, 3));
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < press_pct)
				c.event_kind = EV_PRESS;
			else if (roll < 92)
				c.event_kind = EV_RELEASE;
			else if (roll < 96)
				c.event_kind = EV_NONE;
			else
				c.event_kind = EV_SPARE;
			key = 4'($urandom_range(0, 15));
			if (c.event_kind == EV_RELEASE && held_count > 0 && $urandom_range(0, 3) != 0)
				key = held_keys[$urandom_range(0, held_count - 1)];
			c.key_scancode = scancode_of_key(key);
		end
		return c;
	endfunction

	function automatic int gap_cycles(input int idx);
		int unsigned roll;
		if (idx % 256 < 64)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic issue_key_event(input hkpt_cmd_t c, input logic typed,
			input hkpt_rsp_t want);
		hkpt_rsp_t predicted;
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = track_key_event(c);
		if (typed)
			predicted = want;
		expected_key_status = {expected_key_status, predicted};
	endtask

	task automatic hold_off(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [3:0] want,
			input logic [3:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		hkpt_rsp_t want;
		if (done === 1'b1) begin
			if (expected_key_status.size() == 0) begin
				mismatch_count++;
				$display("%0t: result expected none, got %b", $time, result);
			end else begin
				want = expected_key_status.pop_front();
				check_field("query_key_down", 4'(want.query_key_down),
					4'(result.query_key_down));
				check_field("first_key", want.first_key, result.first_key);
				check_field("first_key_valid", 4'(want.first_key_valid),
					4'(result.first_key_valid));
				check_field("scancode_mapped", 4'(want.scancode_mapped),
					4'(result.scancode_mapped));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = '0;
		held_count     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		for (int i = 0; i < KEY_SLOTS; i++)
			held_keys[i] = 4'd0;

		// Typed results are packed as {down, first_key, valid, mapped}.
		directed_rows[0] = key_row(9'd0, EV_NONE, 4'd0, 1'b1, 7'b0_0000_0_0);
		directed_rows[1] = key_row(9'd511, EV_PRESS, 4'd15, 1'b1, 7'b0_0000_0_0);
		directed_rows[2] = key_row(9'd27, EV_PRESS, 4'd0, 1'b1, 7'b1_0000_1_1);
		directed_rows[3] = key_row(9'd27, EV_PRESS, 4'd15, 1'b0, '0);
		directed_rows[4] = key_row(9'd30, EV_SPARE, 4'd1, 1'b0, '0);
		directed_rows[5] = key_row(9'd31, EV_RELEASE, 4'd2, 1'b0, '0);
		directed_rows[6] = key_row(9'd25, EV_PRESS, 4'd15, 1'b0, '0);
		directed_rows[7] = key_row(9'd27, EV_RELEASE, 4'd0, 1'b0, '0);
		directed_rows[8] = key_row(9'd25, EV_RELEASE, 4'd15, 1'b1, 7'b0_0000_0_1);
		// Fill the list with every key, highest first, so the oldest key is not zero.
		for (int k = 0; k < 16; k++)
			directed_rows[9 + k] = key_row(scancode_of_key(4'(15 - k)), EV_PRESS,
				4'(k), 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++) begin
			issue_key_event(directed_rows[i].cmd, directed_rows[i].typed,
				directed_rows[i].want);
			hold_off(gap_cycles(i));
		end
		for (int i = 0; i < RANDOM_N; i++) begin
			issue_key_event(random_key_event(((i / 80) % 2 == 0) ? 25 : 72), 1'b0, '0);
			hold_off(gap_cycles(i));
		end
		start <= 1'b0;

		while (expected_key_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/hkpt_pkg.sv
sv/hkpt_list_ram.sv
sv/hex_keypad_press_order_tracker.sv
test/hex_keypad_press_order_tracker_tb.sv
